@@ hw/rtl/env_sensor_compensation_defines.svh @@
// Assertion macros for the environmental sensor compensation block.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ESC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/esc_pkg.sv @@
// Shared types, constants and a helper function for sensor compensation.
package esc_pkg;

   localparam int DIV_STAGES = 32;

   localparam logic [2:0] REG_TEMP_CALIB    = 3'd0;
   localparam logic [2:0] REG_PRESS_CALIB_A = 3'd1;
   localparam logic [2:0] REG_PRESS_CALIB_B = 3'd2;
   localparam logic [2:0] REG_MIXED_CALIB   = 3'd3;
   localparam logic [2:0] REG_HUM_CALIB     = 3'd4;
   localparam logic [2:0] REG_FEATURE       = 3'd5;

   // ceil(2^31 / 100): exact divide by 100 for magnitudes below 2^24
   localparam logic [24:0] TEMP_RECIP = 25'd21474837;

   // Data that rides alongside the divider pipeline
   typedef struct packed {
      logic signed [15:0] temp_whole;
      logic signed [10:0] temp_milli;
      logic signed [31:0] hum_h;
      logic signed [31:0] hum_ss;
      logic               div_zero;
      logic               big;
   } side_type;

   // 32-bit wrapping signed multiply
   function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

endpackage

@@ hw/rtl/esc_div.sv @@
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module esc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        in_num,
   input  logic [31:0]        in_den,
   input  esc_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [31:0]        out_quo,
   output esc_pkg::side_type  out_side
);

   logic              vld_ff  [esc_pkg::DIV_STAGES];
   logic [31:0]       rem_ff  [esc_pkg::DIV_STAGES];
   logic [31:0]       nq_ff   [esc_pkg::DIV_STAGES];
   logic [31:0]       den_ff  [esc_pkg::DIV_STAGES];
   esc_pkg::side_type side_ff [esc_pkg::DIV_STAGES];

   for (genvar i = 0; i < esc_pkg::DIV_STAGES; i++) begin : g_stage
      logic              cur_vld;
      logic [31:0]       cur_rem;
      logic [31:0]       cur_nq;
      logic [31:0]       cur_den;
      esc_pkg::side_type cur_side;
      logic [32:0]       trial;
      logic              ge;
      logic [31:0]       rem_in;
      logic [31:0]       nq_in;

      if (i == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_rem  = '0;
         assign cur_nq   = in_num;
         assign cur_den  = in_den;
         assign cur_side = in_side;
      end else begin : g_rest
         assign cur_vld  = vld_ff[i-1];
         assign cur_rem  = rem_ff[i-1];
         assign cur_nq   = nq_ff[i-1];
         assign cur_den  = den_ff[i-1];
         assign cur_side = side_ff[i-1];
      end

      always_comb begin
         trial  = {cur_rem, cur_nq[31]};
         ge     = trial >= {1'b0, cur_den};
         rem_in = ge ? 32'(trial - {1'b0, cur_den}) : trial[31:0];
         nq_in  = {cur_nq[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= nq_in;
            den_ff[i]  <= cur_den;
            side_ff[i] <= cur_side;
         end
      end
   end

   assign out_valid = vld_ff[esc_pkg::DIV_STAGES-1];
   assign out_quo   = nq_ff[esc_pkg::DIV_STAGES-1];
   assign out_side  = side_ff[esc_pkg::DIV_STAGES-1];

endmodule

@@ hw/rtl/env_sensor_compensation.sv @@
// Top level: integer temperature, pressure and humidity compensation pipeline.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | raw pressure, temperature, humidity
//   rsp     | out | rsp_valid/stall    | temperature, pressure, humidity, flags
//   csr     | in  | csr_write_enable   | csr_index, csr_wdata
//
// One item per cycle while not held; 8 front stages, 32 divider stages,
// 3 back stages. The pressure divider sets the depth.
// Synchronous active-high reset clears valid bits and calibration registers.
// The whole pipeline holds while a result waits under rsp_stall.
module env_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temp_whole,
   output logic signed [10:0] rsp_temp_milli,
   output logic [31:0]        rsp_pressure_pa,
   output logic               rsp_pressure_valid,
   output logic               rsp_pressure_div_zero,
   output logic [6:0]         rsp_humidity_percent,
   output logic               rsp_humidity_valid,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   `include "env_sensor_compensation_defines.svh"

   // csr registers
   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [47:0] mixed_ff;
   logic [39:0] hum_calib_ff;
   logic [1:0]  feature_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         mixed_ff      <= '0;
         hum_calib_ff  <= '0;
         feature_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            esc_pkg::REG_TEMP_CALIB:    temp_calib_ff <= csr_wdata[47:0];
            esc_pkg::REG_PRESS_CALIB_A: press_a_ff    <= csr_wdata;
            esc_pkg::REG_PRESS_CALIB_B: press_b_ff    <= csr_wdata;
            esc_pkg::REG_MIXED_CALIB:   mixed_ff      <= csr_wdata[47:0];
            esc_pkg::REG_HUM_CALIB:     hum_calib_ff  <= csr_wdata[39:0];
            esc_pkg::REG_FEATURE:       feature_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // calibration fields
   logic signed [31:0] t1, t2, t3;
   logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [31:0] h1, h2, h3, h4, h5, h6;

   assign t1 = $signed({16'd0, temp_calib_ff[15:0]});
   assign t2 = $signed(temp_calib_ff[31:16]);
   assign t3 = $signed(temp_calib_ff[47:32]);
   assign p1 = $signed({16'd0, press_a_ff[15:0]});
   assign p2 = $signed(press_a_ff[31:16]);
   assign p3 = $signed(press_a_ff[47:32]);
   assign p4 = $signed(press_a_ff[63:48]);
   assign p5 = $signed(press_b_ff[15:0]);
   assign p6 = $signed(press_b_ff[31:16]);
   assign p7 = $signed(press_b_ff[47:32]);
   assign p8 = $signed(press_b_ff[63:48]);
   assign p9 = $signed(mixed_ff[15:0]);
   assign h1 = $signed({24'd0, mixed_ff[23:16]});
   assign h2 = $signed(mixed_ff[39:24]);
   assign h3 = $signed({24'd0, mixed_ff[47:40]});
   assign h4 = $signed(hum_calib_ff[15:0]);
   assign h5 = $signed(hum_calib_ff[31:16]);
   assign h6 = $signed(hum_calib_ff[39:32]);

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage registers
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s5_vld_ff, s6_vld_ff, s7_vld_ff, s8_vld_ff;
   logic e1_vld_ff, e2_vld_ff, e3_vld_ff;

   logic signed [31:0] s1_m1_ff, s1_m2_ff;
   logic [19:0]        s1_adcp_ff, s2_adcp_ff, s3_adcp_ff, s4_adcp_ff;
   logic [19:0]        s5_adcp_ff, s6_adcp_ff;
   logic [15:0]        s1_adch_ff, s2_adch_ff, s3_adch_ff, s4_adch_ff;
   logic signed [31:0] s2_var1_ff, s2_m3_ff;
   logic signed [31:0] s3_tf_ff;
   logic signed [31:0] s4_cent_ff, s4_v0_ff, s4_sq_ff, s4_mx6_ff, s4_mx3_ff, s4_m5_ff;
   logic               s5_neg_ff;
   logic [23:0]        s5_mag_ff;
   logic [48:0]        s5_tprod_ff;
   logic signed [31:0] s5_v1a_ff, s5_v1b_ff, s5_pt3_ff, s5_pt2_ff, s5_hv1_ff, s5_hh_ff;
   logic signed [15:0] s6_tw_ff, s7_tw_ff, s8_tw_ff;
   logic signed [10:0] s6_tm_ff, s7_tm_ff, s8_tm_ff;
   logic signed [31:0] s6_v1_ff, s6_v0b_ff, s6_hm_ff, s6_hh_ff;
   logic signed [31:0] s7_v0c_ff, s7_pre_ff, s7_h_ff;
   logic [31:0]        s8_p_ff;
   logic signed [31:0] s8_dv_ff, s8_h_ff, s8_ss_ff;
   logic               s8_dz_ff;

   // combinational next values
   logic signed [31:0] s1_m1_in, s1_m2_in, ta, td;
   logic signed [31:0] s4_v0_in, s4_q, s4_sq_in, s4_x, s4_cent_in;
   logic signed [31:0] s5_cabs;
   logic signed [31:0] s5_hv1_in, s5_hh_in;
   logic [17:0]        s6_q;
   logic [6:0]         s6_rem;
   logic [10:0]        s6_m;
   logic signed [15:0] s6_tw_in;
   logic signed [10:0] s6_tm_in;
   logic signed [31:0] s6_v1_in, s6_v0b_in;
   logic signed [31:0] s7_v0c_in, s7_pre_in, s7_k;
   logic signed [31:0] s8_s;

   always_comb begin
      ta       = $signed({15'd0, req_raw_temperature[19:3]}) - (t1 <<< 1);
      td       = $signed({16'd0, req_raw_temperature[19:4]}) - t1;
      s1_m1_in = esc_pkg::mul32(ta, t2);
      s1_m2_in = esc_pkg::mul32(td, td);

      s4_cent_in = (esc_pkg::mul32(s3_tf_ff, 32'sd5) + 32'sd128) >>> 8;
      s4_v0_in   = (s3_tf_ff >>> 1) - 32'sd64000;
      s4_q       = s4_v0_in >>> 2;
      s4_sq_in   = esc_pkg::mul32(s4_q, s4_q);
      s4_x       = s3_tf_ff - 32'sd76800;

      s5_cabs   = s4_cent_ff[31] ? -s4_cent_ff : s4_cent_ff;
      s5_hv1_in = esc_pkg::mul32(s4_mx6_ff >>> 10, (s4_mx3_ff >>> 11) + 32'sd32768);
      s5_hh_in  = ($signed({2'd0, s4_adch_ff, 14'd0}) - (h4 <<< 20) - s4_m5_ff
                   + 32'sd16384) >>> 15;

      s6_q   = s5_tprod_ff[48:31];
      s6_rem = 7'(s5_mag_ff - 24'(s6_q * 24'd100));
      s6_m   = {4'd0, s6_rem} * 11'd10;
      if (s6_q > 18'd32767) begin
         s6_tw_in = s5_neg_ff ? 16'sh8000 : 16'sh7FFF;
      end else begin
         s6_tw_in = s5_neg_ff ? -$signed(s6_q[15:0]) : $signed(s6_q[15:0]);
      end
      s6_tm_in  = s5_neg_ff ? -$signed(s6_m) : $signed(s6_m);
      s6_v1_in  = (((s5_v1a_ff + (s5_v1b_ff <<< 1)) >>> 2) + (p4 <<< 16));
      s6_v0b_in = ((s5_pt3_ff >>> 3) + (s5_pt2_ff >>> 1)) >>> 18;

      s7_v0c_in = esc_pkg::mul32(32'sd32768 + s6_v0b_ff, p1) >>> 15;
      s7_pre_in = (32'sd1048576 - $signed({12'd0, s6_adcp_ff})) - (s6_v1_ff >>> 12);
      s7_k      = (s6_hm_ff + 32'sd8192) >>> 14;

      s8_s = s7_h_ff >>> 15;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m1_ff   <= s1_m1_in;
         s1_m2_ff   <= s1_m2_in;
         s1_adcp_ff <= req_raw_pressure;
         s1_adch_ff <= req_raw_humidity;

         s2_var1_ff <= s1_m1_ff >>> 11;
         s2_m3_ff   <= esc_pkg::mul32(s1_m2_ff >>> 12, t3);
         s2_adcp_ff <= s1_adcp_ff;
         s2_adch_ff <= s1_adch_ff;

         s3_tf_ff   <= s2_var1_ff + (s2_m3_ff >>> 14);
         s3_adcp_ff <= s2_adcp_ff;
         s3_adch_ff <= s2_adch_ff;

         s4_cent_ff <= s4_cent_in;
         s4_v0_ff   <= s4_v0_in;
         s4_sq_ff   <= s4_sq_in;
         s4_mx6_ff  <= esc_pkg::mul32(s4_x, h6);
         s4_mx3_ff  <= esc_pkg::mul32(s4_x, h3);
         s4_m5_ff   <= esc_pkg::mul32(h5, s4_x);
         s4_adcp_ff <= s3_adcp_ff;
         s4_adch_ff <= s3_adch_ff;

         s5_neg_ff   <= s4_cent_ff[31];
         s5_mag_ff   <= s5_cabs[23:0];
         s5_tprod_ff <= s5_cabs[23:0] * esc_pkg::TEMP_RECIP;
         s5_v1a_ff   <= esc_pkg::mul32(s4_sq_ff >>> 11, p6);
         s5_v1b_ff   <= esc_pkg::mul32(s4_v0_ff, p5);
         s5_pt3_ff   <= esc_pkg::mul32(p3, s4_sq_ff >>> 13);
         s5_pt2_ff   <= esc_pkg::mul32(p2, s4_v0_ff);
         s5_hv1_ff   <= s5_hv1_in;
         s5_hh_ff    <= s5_hh_in;
         s5_adcp_ff  <= s4_adcp_ff;

         s6_tw_ff   <= s6_tw_in;
         s6_tm_ff   <= s6_tm_in;
         s6_v1_ff   <= s6_v1_in;
         s6_v0b_ff  <= s6_v0b_in;
         s6_hm_ff   <= esc_pkg::mul32((s5_hv1_ff >>> 10) + 32'sd2097152, h2);
         s6_hh_ff   <= s5_hh_ff;
         s6_adcp_ff <= s5_adcp_ff;

         s7_tw_ff  <= s6_tw_ff;
         s7_tm_ff  <= s6_tm_ff;
         s7_v0c_ff <= s7_v0c_in;
         s7_pre_ff <= s7_pre_in;
         s7_h_ff   <= esc_pkg::mul32(s6_hh_ff, s7_k);

         s8_tw_ff <= s7_tw_ff;
         s8_tm_ff <= s7_tm_ff;
         s8_p_ff  <= 32'(s7_pre_ff) * 32'd3125;
         s8_dv_ff <= s7_v0c_ff;
         s8_dz_ff <= s7_v0c_ff == 32'sd0;
         s8_h_ff  <= s7_h_ff;
         s8_ss_ff <= esc_pkg::mul32(s8_s, s8_s);
      end
   end

   // divider
   esc_pkg::side_type div_side_in, div_side_out;
   logic [31:0]       div_num;
   logic              div_vld_out;
   logic [31:0]       div_quo;

   always_comb begin
      div_side_in.temp_whole = s8_tw_ff;
      div_side_in.temp_milli = s8_tm_ff;
      div_side_in.hum_h      = s8_h_ff;
      div_side_in.hum_ss     = s8_ss_ff;
      div_side_in.div_zero   = s8_dz_ff;
      div_side_in.big        = s8_p_ff[31];
      div_num = s8_p_ff[31] ? s8_p_ff : {s8_p_ff[30:0], 1'b0};
   end

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s8_vld_ff),
      .in_num    (div_num),
      .in_den    (s8_dv_ff),
      .in_side   (div_side_in),
      .out_valid (div_vld_out),
      .out_quo   (div_quo),
      .out_side  (div_side_out)
   );

   // back stages
   logic [31:0]        e1_p_in, e1_q3;
   logic [31:0]        e1_p_ff, e1_usq_ff, e2_p_ff;
   logic signed [31:0] e1_pb_ff, e1_th_ff, e1_h_ff;
   logic signed [15:0] e1_tw_ff, e2_tw_ff;
   logic signed [10:0] e1_tm_ff, e2_tm_ff;
   logic               e1_dz_ff, e2_dz_ff;
   logic signed [31:0] e2_a_ff, e2_b_ff, e2_hn;
   logic [6:0]         e2_pct_ff, e2_pct_in;
   logic [31:0]        e3_pa_in;

   logic signed [15:0] rsp_temp_whole_ff;
   logic signed [10:0] rsp_temp_milli_ff;
   logic [31:0]        rsp_pressure_pa_ff;
   logic               rsp_div_zero_ff;
   logic [6:0]         rsp_humidity_ff;

   always_comb begin
      e1_p_in = div_side_out.big ? {div_quo[30:0], 1'b0} : div_quo;
      e1_q3   = {3'd0, e1_p_in[31:3]};
      e2_hn   = e1_h_ff - (e1_th_ff >>> 4);
      if (e2_hn[31]) begin
         e2_pct_in = 7'd0;
      end else if (e2_hn[30:22] > 9'd100) begin
         e2_pct_in = 7'd100;
      end else begin
         e2_pct_in = e2_hn[28:22];
      end
      e3_pa_in = 32'($signed(e2_p_ff) + ((e2_a_ff + e2_b_ff + p7) >>> 4));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
      end else if (adv) begin
         e1_vld_ff <= div_vld_out;
         e2_vld_ff <= e1_vld_ff;
         e3_vld_ff <= e2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_p_ff   <= e1_p_in;
         e1_usq_ff <= 32'(e1_q3 * e1_q3);
         e1_pb_ff  <= esc_pkg::mul32($signed({2'd0, e1_p_in[31:2]}), p8);
         e1_th_ff  <= esc_pkg::mul32(div_side_out.hum_ss >>> 7, h1);
         e1_h_ff   <= div_side_out.hum_h;
         e1_tw_ff  <= div_side_out.temp_whole;
         e1_tm_ff  <= div_side_out.temp_milli;
         e1_dz_ff  <= div_side_out.div_zero;

         e2_p_ff   <= e1_p_ff;
         e2_a_ff   <= esc_pkg::mul32(p9, $signed({13'd0, e1_usq_ff[31:13]})) >>> 12;
         e2_b_ff   <= e1_pb_ff >>> 13;
         e2_pct_ff <= e2_pct_in;
         e2_tw_ff  <= e1_tw_ff;
         e2_tm_ff  <= e1_tm_ff;
         e2_dz_ff  <= e1_dz_ff;

         rsp_temp_whole_ff  <= e2_tw_ff;
         rsp_temp_milli_ff  <= e2_tm_ff;
         rsp_pressure_pa_ff <= e2_dz_ff ? 32'd0 : e3_pa_in;
         rsp_div_zero_ff    <= e2_dz_ff;
         rsp_humidity_ff    <= e2_pct_ff;
      end
   end

   assign rsp_valid             = e3_vld_ff;
   assign rsp_temp_whole        = rsp_temp_whole_ff;
   assign rsp_temp_milli        = rsp_temp_milli_ff;
   assign rsp_pressure_valid    = feature_ff[0];
   assign rsp_pressure_pa       = feature_ff[0] ? rsp_pressure_pa_ff : 32'd0;
   assign rsp_pressure_div_zero = feature_ff[0] & rsp_div_zero_ff;
   assign rsp_humidity_valid    = feature_ff[1];
   assign rsp_humidity_percent  = feature_ff[1] ? rsp_humidity_ff : 7'd0;

   `ESC_ASSERT_NOW(a_stall_follows_output, clock, reset, 1'b1,
      req_stall == (rsp_valid && rsp_stall), "input stall does not track output hold")
   `ESC_ASSERT_NOW(a_hum_range, clock, reset, rsp_valid,
      rsp_humidity_percent <= 7'd100, "humidity above 100 percent")
   `ESC_ASSERT_NOW(a_milli_range, clock, reset, rsp_valid,
      (rsp_temp_milli <= 11'sd990) && (rsp_temp_milli >= -11'sd990),
      "millidegree remainder out of range")
   `ESC_ASSERT_NOW(a_div_zero_pa, clock, reset, rsp_valid && rsp_pressure_div_zero,
      rsp_pressure_valid && (rsp_pressure_pa == 32'd0), "zero divisor without zero pressure")

endmodule

@@ test/env_sensor_compensation_tb.sv @@
// Testbench for env_sensor_compensation: random and directed readings checked against a predictor.
`timescale 1ns / 1ps

module env_sensor_compensation_tb;

   typedef struct {
      logic [19:0] pres;
      logic [19:0] temp;
      logic [15:0] hum;
   } reading_type;

   typedef struct {
      logic signed [15:0] temp_whole;
      logic signed [10:0] temp_milli;
      logic [31:0]        pressure_pa;
      logic               pressure_valid;
      logic               pressure_div_zero;
      logic [6:0]         humidity_percent;
      logic               humidity_valid;
   } comp_type;

   // indexes past the last register, writes must be ignored
   localparam logic [2:0] REG_UNUSED_A = 3'd6;
   localparam logic [2:0] REG_UNUSED_B = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [19:0]        req_raw_pressure = '0;
   logic [19:0]        req_raw_temperature = '0;
   logic [15:0]        req_raw_humidity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_temp_whole;
   logic signed [10:0] rsp_temp_milli;
   logic [31:0]        rsp_pressure_pa;
   logic               rsp_pressure_valid;
   logic               rsp_pressure_div_zero;
   logic [6:0]         rsp_humidity_percent;
   logic               rsp_humidity_valid;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   env_sensor_compensation u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // calibration shadow
   logic [47:0] temp_cal, mixed_cal;
   logic [63:0] press_cal_a, press_cal_b;
   logic [39:0] hum_cal;
   logic [1:0]  features;

   reading_type pending_readings[$];
   comp_type    expected_results[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   function automatic comp_type compensate(reading_type r);
      comp_type    c;
      int          t1, t2, t3, var1, var2, d, tf, cent, whole;
      int          p1, p2, p3, p4, p5, p6, p7, p8, p9;
      int          h1, h2, h3, h4, h5, h6;
      int          v0, v1, q, sq, a, b, x, h, s, adc_p, adc_t, adc_h;
      int unsigned pu, dv, q3, usq;
      adc_p = int'(r.pres);
      adc_t = int'(r.temp);
      adc_h = int'(r.hum);
      t1 = int'(temp_cal[15:0]);
      t2 = int'($signed(temp_cal[31:16]));
      t3 = int'($signed(temp_cal[47:32]));
      var1 = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      var2 = (((d * d) >>> 12) * t3) >>> 14;
      tf = var1 + var2;
      cent = (tf * 5 + 128) >>> 8;
      whole = cent / 100;
      c.temp_milli = 11'((cent - whole * 100) * 10);
      if (whole < -32768) whole = -32768;
      if (whole > 32767) whole = 32767;
      c.temp_whole = 16'(whole);
      c.pressure_pa = '0;
      c.pressure_div_zero = 1'b0;
      c.pressure_valid = features[0];
      c.humidity_percent = '0;
      c.humidity_valid = features[1];
      if (features[0]) begin
         p1 = int'(press_cal_a[15:0]);
         p2 = int'($signed(press_cal_a[31:16]));
         p3 = int'($signed(press_cal_a[47:32]));
         p4 = int'($signed(press_cal_a[63:48]));
         p5 = int'($signed(press_cal_b[15:0]));
         p6 = int'($signed(press_cal_b[31:16]));
         p7 = int'($signed(press_cal_b[47:32]));
         p8 = int'($signed(press_cal_b[63:48]));
         p9 = int'($signed(mixed_cal[15:0]));
         v0 = (tf >>> 1) - 64000;
         q = v0 >>> 2;
         sq = q * q;
         v1 = (sq >>> 11) * p6;
         v1 = v1 + ((v0 * p5) <<< 1);
         v1 = (v1 >>> 2) + (p4 <<< 16);
         v0 = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * v0) >>> 1)) >>> 18;
         v0 = ((32768 + v0) * p1) >>> 15;
         if (v0 == 0) begin
            c.pressure_div_zero = 1'b1;
         end else begin
            // arithmetic shift kept signed before the unsigned subtract
            v1 = v1 >>> 12;
            pu = 1048576 - adc_p;
            pu = pu - v1;
            pu = pu * 3125;
            dv = v0;
            if (pu < 32'h8000_0000) pu = (pu << 1) / dv;
            else pu = (pu / dv) << 1;
            q3 = pu >> 3;
            usq = q3 * q3;
            a = (p9 * int'(usq >> 13)) >>> 12;
            b = (int'(pu >> 2) * p8) >>> 13;
            c.pressure_pa = 32'(int'(pu) + ((a + b + p7) >>> 4));
         end
      end
      if (features[1]) begin
         h1 = int'(mixed_cal[23:16]);
         h2 = int'($signed(mixed_cal[39:24]));
         h3 = int'(mixed_cal[47:40]);
         h4 = int'($signed(hum_cal[15:0]));
         h5 = int'($signed(hum_cal[31:16]));
         h6 = int'($signed(hum_cal[39:32]));
         x = tf - 76800;
         v1 = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
         h = (((adc_h <<< 14) - (h4 <<< 20) - (h5 * x)) + 16384) >>> 15;
         h = h * (((((v1 >>> 10) + 2097152) * h2) + 8192) >>> 14);
         s = h >>> 15;
         h = h - ((((s * s) >>> 7) * h1) >>> 4);
         if (h < 0) h = 0;
         h = h >>> 22;
         c.humidity_percent = (h > 100) ? 7'd100 : 7'(h);
      end
      return c;
   endfunction

   // driver
   reading_type cur;
   int          req_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(compensate(cur));
            if ($urandom_range(0, 39) == 0) calm = ~calm;
            req_gap = calm ? 0 : $urandom_range(0, 13);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
               cur = pending_readings.pop_front();
               req_valid <= 1'b1;
               req_raw_pressure <= cur.pres;
               req_raw_temperature <= cur.temp;
               req_raw_humidity <= cur.hum;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int       rsp_hold = 0;
   comp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item at cycle %0d", cycles);
         end else begin
            want = expected_results.pop_front();
            if (rsp_temp_whole !== want.temp_whole || rsp_temp_milli !== want.temp_milli
                || rsp_pressure_pa !== want.pressure_pa
                || rsp_pressure_valid !== want.pressure_valid
                || rsp_pressure_div_zero !== want.pressure_div_zero
                || rsp_humidity_percent !== want.humidity_percent
                || rsp_humidity_valid !== want.humidity_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp t=%0d m=%0d p=%0d pv=%0d dz=%0d h=%0d hv=%0d %s",
                           want.temp_whole, want.temp_milli, want.pressure_pa,
                           want.pressure_valid, want.pressure_div_zero,
                           want.humidity_percent, want.humidity_valid,
                           $sformatf("got t=%0d m=%0d p=%0d pv=%0d dz=%0d h=%0d hv=%0d",
                              rsp_temp_whole, rsp_temp_milli, rsp_pressure_pa,
                              rsp_pressure_valid, rsp_pressure_div_zero,
                              rsp_humidity_percent, rsp_humidity_valid));
            end
         end
         rsp_hold = calm ? 0 : $urandom_range(0, 13);
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
      if (cycles > 600000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         esc_pkg::REG_TEMP_CALIB:    temp_cal = val[47:0];
         esc_pkg::REG_PRESS_CALIB_A: press_cal_a = val;
         esc_pkg::REG_PRESS_CALIB_B: press_cal_b = val;
         esc_pkg::REG_MIXED_CALIB:   mixed_cal = val[47:0];
         esc_pkg::REG_HUM_CALIB:     hum_cal = val[39:0];
         esc_pkg::REG_FEATURE:       features = val[1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_all(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [63:0] m, logic [63:0] h, logic [1:0] f);
      write_reg(esc_pkg::REG_TEMP_CALIB, t);
      write_reg(esc_pkg::REG_PRESS_CALIB_A, pa);
      write_reg(esc_pkg::REG_PRESS_CALIB_B, pb);
      write_reg(esc_pkg::REG_MIXED_CALIB, m);
      write_reg(esc_pkg::REG_HUM_CALIB, h);
      write_reg(esc_pkg::REG_FEATURE, {62'd0, f});
   endtask

   // checked away from the rising edge so driver updates have settled
   task automatic drain();
      while (pending_readings.size() > 0 || expected_results.size() > 0 || req_valid)
         @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic add_reading(logic [19:0] p, logic [19:0] t, logic [15:0] h);
      reading_type r;
      r.pres = p;
      r.temp = t;
      r.hum = h;
      pending_readings.push_back(r);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) != 0)
            add_reading(20'($urandom_range(300000, 500000)),
                        20'($urandom_range(450000, 590000)),
                        16'($urandom_range(15000, 50000)));
         else
            add_reading(20'($urandom()), 20'($urandom()), 16'($urandom()));
      end
   endtask

   // typical datasheet-like calibration
   localparam logic [63:0] T_TYP  = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] PA_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] PB_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [63:0] M_TYP  = {8'd0, 16'd362, 8'd75, 16'd6000};
   localparam logic [63:0] H_TYP  = {8'd30, 16'd50, 16'd324};

   initial begin
      temp_cal = '0; press_cal_a = '0; press_cal_b = '0;
      mixed_cal = '0; hum_cal = '0; features = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset calibration
      add_reading(20'h0, 20'h0, 16'h0);
      add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      drain();

      write_all(T_TYP, PA_TYP, PB_TYP, M_TYP, H_TYP, 2'b11);
      add_reading(20'd415148, 20'd519888, 16'd30000);
      add_reading(20'h0, 20'h0, 16'h0);
      add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_reading(20'h0, 20'hFFFFF, 16'hFFFF);
      add_reading(20'hFFFFF, 20'h0, 16'h0);
      add_reading(20'd300000, 20'd600000, 16'd65000);
      add_reading(20'd500000, 20'd450000, 16'd1000);
      add_random(300);
      drain();

      // zero divisor
      write_reg(esc_pkg::REG_PRESS_CALIB_A, {PA_TYP[63:16], 16'd0});
      write_reg(esc_pkg::REG_FEATURE, 64'd1);
      add_reading(20'd415148, 20'd519888, 16'd30000);
      add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_random(20);
      drain();

      // all ones calibration, extremes
      write_all('1, '1, '1, '1, '1, 2'b11);
      write_reg(REG_UNUSED_A, rand64());
      write_reg(REG_UNUSED_B, rand64());
      add_reading(20'h0, 20'h0, 16'h0);
      add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_reading(20'h80000, 20'h80000, 16'h8000);
      add_random(80);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_all(rand64(), rand64(), rand64(), rand64(), rand64(), 2'($urandom()));
         add_random(100);
         drain();
      end

      write_all(T_TYP, PA_TYP, PB_TYP, M_TYP, H_TYP, 2'b10);
      add_random(50);
      drain();
      write_reg(esc_pkg::REG_FEATURE, 64'd0);
      add_random(30);
      drain();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/esc_pkg.sv
hw/rtl/esc_div.sv
hw/rtl/env_sensor_compensation.sv
test/env_sensor_compensation_tb.sv
